/* rtl/core/rsdfd_pkg.sv */
// ----------------------------------------------------------------------------
// rsdfd_pkg
// shared constants and types for the run/skip/dump frame decoder
// ----------------------------------------------------------------------------
package rsdfd_pkg;

   localparam int OFFSET_BITS_DEFAULT = 16;

   localparam int FRAME_SIZE_W  = 17;
   localparam int DEST_OFFSET_W = 16;
   localparam int FILL_LENGTH_W = 14;
   localparam int PIXEL_W       = 8;
   localparam int SKIP_W        = 15;
   localparam int RSP_DATA_W    = 40;
   localparam int RSP_USER_W    = 2;

   localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 17'd64000;

   typedef enum logic [RSP_USER_W-1:0] {
      KIND_LITERAL = 2'd0,
      KIND_FILL    = 2'd1,
      KIND_END     = 2'd2
   } result_kind_type;

   localparam logic [7:0] OP_LONG        = 8'h80;
   localparam logic [7:0] OP_SHORT_RUN   = 8'h00;

endpackage

/* rtl/core/run_skip_dump_frame_decoder.sv */
// ----------------------------------------------------------------------------
// run_skip_dump_frame_decoder
// decodes run/skip/dump frame-delta bytes into byte writes, fills and end marks
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// req_     in   data_byte[7:0]                          frame_start
// rsp_     out  dest_offset, fill_length, pixel, flag   result_kind
// csr_     in   frame_size[16:0] on csr_wr_en           -
//
// one req byte per cycle sustained while rsp is not stalled; an accepted req byte
// passes the input register, then decodes into the result register
// synchronous active-high reset returns to opcode phase, offset zero,
// frame_size 64000
// a stalled rsp word holds and blocks decode; req stalls once rsp is stalled and the input
// register is full
// ----------------------------------------------------------------------------
module run_skip_dump_frame_decoder #(
   parameter int OFFSET_BITS = rsdfd_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // data_byte
   input  logic                                 req_tuser,   // frame_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // dest_offset[15:0], fill_length[29:16], pixel_value[37:30], beyond_frame[38]
   output logic [rsdfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [rsdfd_pkg::RSP_USER_W-1:0]     rsp_tuser,   // result_kind
   input  logic                                 csr_wr_en,
   input  logic [rsdfd_pkg::FRAME_SIZE_W-1:0]   csr_wr_data  // frame_size
);

   localparam int OFF_W = OFFSET_BITS + 1;
   localparam int SUM_W = ((OFF_W > rsdfd_pkg::FRAME_SIZE_W) ? OFF_W
                                                             : rsdfd_pkg::FRAME_SIZE_W) + 1;
   localparam logic [SUM_W-1:0] OFF_LIMIT  = SUM_W'(1) << OFFSET_BITS;
   localparam logic [SUM_W-1:0] SHOWN_MAX  = SUM_W'(16'hFFFF);
   localparam int LEN_W = rsdfd_pkg::FILL_LENGTH_W;

   typedef enum logic [2:0] {
      PH_OPCODE    = 3'd0,
      PH_DUMP      = 3'd1,
      PH_RUN_COUNT = 3'd2,
      PH_RUN_PIXEL = 3'd3,
      PH_LONG_LO   = 3'd4,
      PH_LONG_HI   = 3'd5,
      PH_LONG_PIX  = 3'd6
   } phase_type;

   logic                                in_valid_ff;
   logic [7:0]                          in_byte_ff;
   logic                                in_start_ff;
   logic                                out_valid_ff;
   logic [rsdfd_pkg::RSP_DATA_W-1:0]    out_data_ff;
   logic [rsdfd_pkg::RSP_USER_W-1:0]    out_user_ff;
   phase_type                           phase_ff;
   logic [OFF_W-1:0]                    offset_ff;
   logic [LEN_W-1:0]                    pending_ff;
   logic [7:0]                          low_ff;
   logic [rsdfd_pkg::FRAME_SIZE_W-1:0]  frame_size_ff;

   phase_type                           phase_in;
   logic [OFF_W-1:0]                    offset_in;
   logic [LEN_W-1:0]                    pending_in;
   logic [7:0]                          low_in;
   logic [rsdfd_pkg::RSP_DATA_W-1:0]    out_data_in;

   logic                                out_free;
   logic                                do_step;
   phase_type                           cur_phase;
   logic [OFF_W-1:0]                    cur_off;
   logic [LEN_W-1:0]                    cur_pend;
   logic [7:0]                          cur_low;
   logic [15:0]                         word;
   logic [LEN_W-1:0]                    pend_dec;
   logic                                emit;
   rsdfd_pkg::result_kind_type          kind;
   logic [LEN_W-1:0]                    len;
   logic [7:0]                          pix;
   logic                                do_adv;
   logic                                clear_off;
   logic [rsdfd_pkg::SKIP_W-1:0]        adv_amt;
   logic [SUM_W-1:0]                    off_ext;
   logic [SUM_W-1:0]                    sum;
   logic [15:0]                         shown;
   logic                                beyond;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_free;
   assign do_step    = in_valid_ff && out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   always_comb begin
      cur_phase = in_start_ff ? PH_OPCODE : phase_ff;
      cur_off   = in_start_ff ? '0 : offset_ff;
      cur_pend  = in_start_ff ? '0 : pending_ff;
      cur_low   = in_start_ff ? '0 : low_ff;
      word      = {in_byte_ff, cur_low};
      pend_dec  = cur_pend - LEN_W'(1);

      phase_in   = cur_phase;
      pending_in = cur_pend;
      low_in     = cur_low;
      emit       = 1'b0;
      kind       = rsdfd_pkg::KIND_LITERAL;
      len        = '0;
      pix        = '0;
      do_adv     = 1'b0;
      clear_off  = 1'b0;
      adv_amt    = '0;

      case (cur_phase)
         PH_DUMP: begin
            pending_in = pend_dec;
            if (pend_dec == '0) phase_in = PH_OPCODE;
            emit    = 1'b1;
            kind    = rsdfd_pkg::KIND_LITERAL;
            len     = LEN_W'(1);
            pix     = in_byte_ff;
            do_adv  = 1'b1;
            adv_amt = rsdfd_pkg::SKIP_W'(1);
         end
         PH_RUN_COUNT: begin
            pending_in = LEN_W'(in_byte_ff);
            phase_in   = PH_RUN_PIXEL;
         end
         PH_RUN_PIXEL, PH_LONG_PIX: begin
            phase_in = PH_OPCODE;
            if (cur_pend != '0) begin
               pending_in = '0;
               emit       = 1'b1;
               kind       = rsdfd_pkg::KIND_FILL;
               len        = cur_pend;
               pix        = in_byte_ff;
               do_adv     = 1'b1;
               adv_amt    = rsdfd_pkg::SKIP_W'(cur_pend);
            end
         end
         PH_LONG_LO: begin
            low_in   = in_byte_ff;
            phase_in = PH_LONG_HI;
         end
         PH_LONG_HI: begin
            phase_in = PH_OPCODE;
            if (word == '0) begin
               emit      = 1'b1;
               kind      = rsdfd_pkg::KIND_END;
               clear_off = 1'b1;
            end else if (!word[15]) begin
               do_adv  = 1'b1;
               adv_amt = word[14:0];
            end else if (word[14]) begin
               pending_in = word[13:0];
               phase_in   = PH_LONG_PIX;
            end else if (word[13:0] != '0) begin
               pending_in = word[13:0];
               phase_in   = PH_DUMP;
            end
         end
         default: begin
            phase_in = PH_OPCODE;
            if (in_byte_ff == rsdfd_pkg::OP_SHORT_RUN) begin
               phase_in = PH_RUN_COUNT;
            end else if (!in_byte_ff[7]) begin
               pending_in = LEN_W'(in_byte_ff);
               phase_in   = PH_DUMP;
            end else if (in_byte_ff == rsdfd_pkg::OP_LONG) begin
               phase_in = PH_LONG_LO;
            end else begin
               do_adv  = 1'b1;
               adv_amt = rsdfd_pkg::SKIP_W'(in_byte_ff[6:0]);
            end
         end
      endcase

      off_ext = SUM_W'(cur_off);
      sum     = off_ext + SUM_W'(adv_amt);
      shown   = (off_ext > SHOWN_MAX) ? 16'hFFFF : off_ext[15:0];
      beyond  = (kind != rsdfd_pkg::KIND_END) && (sum > SUM_W'(frame_size_ff));

      if (clear_off) offset_in = '0;
      else if (do_adv) offset_in = (sum > OFF_LIMIT) ? OFF_W'(OFF_LIMIT) : OFF_W'(sum);
      else offset_in = cur_off;

      out_data_in = {1'b0, beyond, pix, len, shown};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_OPCODE;
         offset_ff     <= '0;
         pending_ff    <= '0;
         low_ff        <= '0;
         frame_size_ff <= rsdfd_pkg::FRAME_SIZE_RESET;
      end else begin
         if (csr_wr_en) frame_size_ff <= csr_wr_data;
         if (req_tready) in_valid_ff <= req_tvalid;
         if (out_free) out_valid_ff <= do_step && emit;
         if (do_step) begin
            phase_ff   <= phase_in;
            offset_ff  <= offset_in;
            pending_ff <= pending_in;
            low_ff     <= low_in;
         end
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      if (do_step && emit) begin
         out_data_ff <= out_data_in;
         out_user_ff <= kind;
      end
   end

endmodule

/* rtl/core/rsdfd_checker.sv */
// ----------------------------------------------------------------------------
// rsdfd_checker
// port-level checks on the decoder result channel, bound to the decoder module
// ----------------------------------------------------------------------------
module rsdfd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rsdfd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [rsdfd_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   // no undefined result kind
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == rsdfd_pkg::KIND_LITERAL ||
                      rsp_tuser == rsdfd_pkg::KIND_FILL ||
                      rsp_tuser == rsdfd_pkg::KIND_END))
      else $error("rsp word carries an undefined kind");

   // end marker carries no length, pixel or flag
   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == rsdfd_pkg::KIND_END) |-> (rsp_tdata[39:16] == '0))
      else $error("end marker word with nonzero fields");

   // literal writes are one byte, fills never empty
   a_lengths: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser != rsdfd_pkg::KIND_LITERAL || rsp_tdata[29:16] == 14'd1) &&
                      (rsp_tuser != rsdfd_pkg::KIND_FILL || rsp_tdata[29:16] != 14'd0)))
      else $error("literal or fill word with bad length");

   // a stalled word stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled rsp word changed");

endmodule

bind run_skip_dump_frame_decoder rsdfd_checker u_rsdfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
